FILE: rtl/assert_macros.svh
// assertion macros used by the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SSAB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ssab check failed");

// consequent that must hold in the cycle after the antecedent
`define SSAB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ssab check failed");

`endif

FILE: rtl/ssab_pkg.sv
// types, constants and pipeline layout of the soft shape alpha blender
package ssab_pkg;

  // image limits, pixels beyond them are never covered
  localparam int unsigned IMG_WIDTH  = 1024;
  localparam int unsigned IMG_HEIGHT = 1024;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PIX_W      = 10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_MODE    = 3'd0,
    REG_CENTER_X      = 3'd1,
    REG_CENTER_Y      = 3'd2,
    REG_RADIUS        = 3'd3,
    REG_FEATHER       = 3'd4,
    REG_FILL_COLOR    = 3'd5,
    REG_RECT_CORNER_A = 3'd6,
    REG_RECT_CORNER_B = 3'd7
  } cfg_reg_e;

  // shape modes
  localparam logic MODE_CIRCLE = 1'b0;
  localparam logic MODE_RECT   = 1'b1;

  // 2^32 / 255 rounded down, x / 255 then needs at most one correction
  localparam logic [24:0] RECIP_255 = 25'h1010101;

  // pipeline layout
  localparam int unsigned SQ_BITS     = 20;
  localparam int unsigned CD_BITS     = 8;
  localparam int unsigned OD_BITS     = 9;
  localparam int unsigned ST_SQ0      = 3;
  localparam int unsigned ST_NUM      = ST_SQ0 + SQ_BITS;
  localparam int unsigned ST_CD0      = ST_NUM + 1;
  localparam int unsigned ST_COV      = ST_CD0 + CD_BITS;
  localparam int unsigned ST_MUL      = ST_COV + 1;
  localparam int unsigned ST_X        = ST_MUL + 1;
  localparam int unsigned ST_PR       = ST_X + 1;
  localparam int unsigned ST_CORR     = ST_PR + 1;
  localparam int unsigned ST_SUM      = ST_CORR + 1;
  localparam int unsigned ST_DIV_INIT = ST_SUM + 1;
  localparam int unsigned ST_OD0      = ST_DIV_INIT + 1;
  localparam int unsigned ST_OUT      = ST_OD0 + OD_BITS;
  localparam int unsigned NUM_STAGES  = ST_OUT + 1;

  // everything one pixel carries down the pipeline
  typedef struct packed {
    logic [3:0][7:0]  dst;
    logic             in_img;
    logic             rect_hit;
    logic [15:0]      adx;
    logic [15:0]      ady;
    logic [31:0]      sqx;
    logic [31:0]      sqy;
    logic [32:0]      d2;
    logic             outside;
    logic             full;
    logic [39:0]      sv;
    logic [21:0]      srem;
    logic [19:0]      sres;
    logic [32:0]      dnum;
    logic             sat;
    logic [7:0]       cq;
    logic [7:0]       sa;
    logic [15:0]      daida;
    logic [2:0][15:0] sp;
    logic [3:0][23:0] x;
    logic [3:0][48:0] pr;
    logic [3:0][15:0] qd;
    logic [8:0]       outa;
    logic [2:0][16:0] prem;
    logic [2:0][17:0] orem;
    logic [2:0][8:0]  oq;
    logic [3:0][7:0]  res;
    logic             touch;
  } pipe_t;

endpackage

FILE: rtl/ssab_ifs.sv
// pixel and configuration channel interfaces

// destination pixel in
interface ssab_in_if import ssab_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_x;
  logic [PIX_W-1:0] pix_y;
  logic [7:0]       dst_r;
  logic [7:0]       dst_g;
  logic [7:0]       dst_b;
  logic [7:0]       dst_a;
  modport source (output valid, pix_x, pix_y, dst_r, dst_g, dst_b, dst_a, input ready);
  modport sink (input valid, pix_x, pix_y, dst_r, dst_g, dst_b, dst_a, output ready);
endinterface

// blended pixel out
interface ssab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_r;
  logic [7:0] out_g;
  logic [7:0] out_b;
  logic [7:0] out_a;
  logic       touched;
  modport source (output valid, out_r, out_g, out_b, out_a, touched, input ready);
  modport sink (input valid, out_r, out_g, out_b, out_a, touched, output ready);
endinterface

// register write channel
interface ssab_cfg_if import ssab_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/soft_shape_alpha_blend.sv
// soft shape coverage and source-over blend, 49 stage pipeline
// throughput: one pixel per cycle; the pipeline holds as one while the output waits
// the longest run is the 20 stage square root followed by the 8 stage coverage divide
// reset clears all valid bits and every configuration register to zero
module soft_shape_alpha_blend import ssab_pkg::*; #(
  parameter int unsigned IMG_W = IMG_WIDTH,
  parameter int unsigned IMG_H = IMG_HEIGHT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ssab_cfg_if.sink cfg,
  ssab_in_if.sink  pix_in,
  ssab_out_if.source pix_out
);

  localparam logic [11:0] W_LIM = 12'(IMG_W);
  localparam logic [11:0] H_LIM = 12'(IMG_H);

  logic        shape_mode_q;
  logic [15:0] center_x_q;
  logic [15:0] center_y_q;
  logic [15:0] radius_q;
  logic [15:0] feather_q;
  logic [31:0] fill_color_q;
  logic [23:0] rect_a_q;
  logic [23:0] rect_b_q;
  logic [31:0] r2_q;
  logic [31:0] in2_q;
  logic [15:0] inner;

  pipe_t                 p_q [NUM_STAGES];
  pipe_t                 p_d [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld_q;
  logic                  adv;

  logic signed [17:0] dx, dy;
  logic signed [11:0] ax, ay, bx, by, lox, hix, loy, hiy;
  logic signed [12:0] xs, ys;

  // configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_mode_q <= MODE_CIRCLE;
      center_x_q   <= '0;
      center_y_q   <= '0;
      radius_q     <= '0;
      feather_q    <= '0;
      fill_color_q <= '0;
      rect_a_q     <= '0;
      rect_b_q     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_SHAPE_MODE:    shape_mode_q <= cfg.data[0];
        REG_CENTER_X:      center_x_q   <= cfg.data[15:0];
        REG_CENTER_Y:      center_y_q   <= cfg.data[15:0];
        REG_RADIUS:        radius_q     <= cfg.data[15:0];
        REG_FEATHER:       feather_q    <= cfg.data[15:0];
        REG_FILL_COLOR:    fill_color_q <= cfg.data;
        REG_RECT_CORNER_A: rect_a_q     <= cfg.data[23:0];
        REG_RECT_CORNER_B: rect_b_q     <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  // squared radii derived from the registers
  assign inner = (radius_q > feather_q) ? radius_q - feather_q : '0;

  always_ff @(posedge clk_i) begin
    r2_q  <= radius_q * radius_q;
    in2_q <= inner * inner;
  end

  // pipeline advance, whole pipe stalls while the output waits
  assign adv          = !vld_q[ST_OUT] || pix_out.ready;
  assign pix_in.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], pix_in.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        p_q[s] <= p_d[s];
      end
    end
  end

  // entry stage: distances to the centre and rectangle test
  assign dx = $signed({4'b0, pix_in.pix_x, 4'b1000}) - $signed({{2{center_x_q[15]}}, center_x_q});
  assign dy = $signed({4'b0, pix_in.pix_y, 4'b1000}) - $signed({{2{center_y_q[15]}}, center_y_q});
  assign ax  = $signed(rect_a_q[11:0]);
  assign ay  = $signed(rect_a_q[23:12]);
  assign bx  = $signed(rect_b_q[11:0]);
  assign by  = $signed(rect_b_q[23:12]);
  assign lox = (ax < bx) ? ax : bx;
  assign hix = (ax < bx) ? bx : ax;
  assign loy = (ay < by) ? ay : by;
  assign hiy = (ay < by) ? by : ay;
  assign xs  = $signed({3'b0, pix_in.pix_x});
  assign ys  = $signed({3'b0, pix_in.pix_y});

  always_comb begin
    logic [17:0] dxm, dym;
    logic [23:0] st, tr, rr, dd, num;
    logic [32:0] dv;
    logic [8:0]  cov;
    logic [16:0] mul;
    logic [17:0] rnd;
    logic [7:0]  ida;
    logic [15:0] q0;
    logic [23:0] qm, rm;
    logic [17:0] odv;

    dxm = dx[17] ? 18'(-dx) : 18'(dx);
    dym = dy[17] ? 18'(-dy) : 18'(dy);

    p_d[0]          = '0;
    p_d[0].dst      = {pix_in.dst_a, pix_in.dst_b, pix_in.dst_g, pix_in.dst_r};
    p_d[0].adx      = dxm[15:0];
    p_d[0].ady      = dym[15:0];
    p_d[0].in_img   = ({2'b0, pix_in.pix_x} < W_LIM) && ({2'b0, pix_in.pix_y} < H_LIM);
    p_d[0].rect_hit = (xs >= lox) && (xs <= hix) && (ys >= loy) && (ys <= hiy);

    for (int s = 1; s < NUM_STAGES; s++) begin
      p_d[s] = p_q[s-1];
    end

    // squares of the offsets
    p_d[1].sqx = p_q[0].adx * p_q[0].adx;
    p_d[1].sqy = p_q[0].ady * p_q[0].ady;

    // squared distance against the radii
    p_d[2].d2      = {1'b0, p_q[1].sqx} + {1'b0, p_q[1].sqy};
    p_d[2].outside = p_d[2].d2 > {1'b0, r2_q};
    p_d[2].full    = (feather_q == '0) || (p_d[2].d2 <= {1'b0, in2_q});
    p_d[2].sv      = {p_d[2].d2[31:0], 8'b0};
    p_d[2].srem    = '0;
    p_d[2].sres    = '0;

    // square root, one result bit per stage
    for (int k = 0; k < SQ_BITS; k++) begin
      st = {p_q[ST_SQ0+k-1].srem, p_q[ST_SQ0+k-1].sv[2*(SQ_BITS-1-k) +: 2]};
      tr = {2'b0, p_q[ST_SQ0+k-1].sres, 2'b01};
      if (st >= tr) begin
        p_d[ST_SQ0+k].srem = 22'(st - tr);
        p_d[ST_SQ0+k].sres = {p_q[ST_SQ0+k-1].sres[SQ_BITS-2:0], 1'b1};
      end else begin
        p_d[ST_SQ0+k].srem = st[21:0];
        p_d[ST_SQ0+k].sres = {p_q[ST_SQ0+k-1].sres[SQ_BITS-2:0], 1'b0};
      end
    end

    // ramp numerator and rounded dividend
    rr  = {radius_q, 8'b0};
    dd  = {4'b0, p_q[ST_NUM-1].sres};
    num = (rr > dd) ? rr - dd : '0;
    p_d[ST_NUM].dnum = {1'b0, num, 8'b0} + {14'b0, feather_q, 3'b0};
    p_d[ST_NUM].sat  = p_d[ST_NUM].dnum >= {5'b0, feather_q, 12'b0};
    p_d[ST_NUM].cq   = '0;

    // coverage divide, one quotient bit per stage
    for (int k = 0; k < CD_BITS; k++) begin
      dv = {13'b0, feather_q, 4'b0} << (CD_BITS - 1 - k);
      if (p_q[ST_CD0+k-1].dnum >= dv) begin
        p_d[ST_CD0+k].dnum = p_q[ST_CD0+k-1].dnum - dv;
        p_d[ST_CD0+k].cq[CD_BITS-1-k] = 1'b1;
      end
    end

    // coverage select and scaled source alpha
    if (!p_q[ST_COV-1].in_img) begin
      cov = '0;
    end else if (shape_mode_q == MODE_RECT) begin
      cov = p_q[ST_COV-1].rect_hit ? 9'd256 : 9'd0;
    end else if ((radius_q <= 16'd8) || p_q[ST_COV-1].outside) begin
      cov = '0;
    end else if (p_q[ST_COV-1].full || p_q[ST_COV-1].sat) begin
      cov = 9'd256;
    end else begin
      cov = {1'b0, p_q[ST_COV-1].cq};
    end
    mul = 17'(fill_color_q[31:24]) * 17'(cov);
    rnd = {1'b0, mul} + 18'd128;
    p_d[ST_COV].sa = rnd[15:8];

    // destination weight and source products
    ida = 8'd255 - p_q[ST_MUL-1].sa;
    p_d[ST_MUL].daida = p_q[ST_MUL-1].dst[3] * ida;
    for (int c = 0; c < 3; c++) begin
      p_d[ST_MUL].sp[c] = fill_color_q[8*c +: 8] * p_q[ST_MUL-1].sa;
    end

    // terms to be divided by 255
    p_d[ST_X].x[3] = {8'b0, p_q[ST_X-1].daida} + 24'd127;
    for (int c = 0; c < 3; c++) begin
      p_d[ST_X].x[c] = ({16'b0, p_q[ST_X-1].dst[c]} * {8'b0, p_q[ST_X-1].daida}) + 24'd127;
    end

    // reciprocal multiply
    for (int c = 0; c < 4; c++) begin
      p_d[ST_PR].pr[c] = {25'b0, p_q[ST_PR-1].x[c]} * {24'b0, RECIP_255};
    end

    // one step correction of the quotient
    for (int c = 0; c < 4; c++) begin
      q0 = p_q[ST_CORR-1].pr[c][47:32];
      qm = {q0, 8'b0} - {8'b0, q0};
      rm = p_q[ST_CORR-1].x[c] - qm;
      p_d[ST_CORR].qd[c] = (rm >= 24'd255) ? q0 + 16'd1 : q0;
    end

    // blended alpha and premultiplied colour
    p_d[ST_SUM].outa = 9'(p_q[ST_SUM-1].sa) + 9'(p_q[ST_SUM-1].qd[3]);
    for (int c = 0; c < 3; c++) begin
      p_d[ST_SUM].prem[c] = 17'(p_q[ST_SUM-1].sp[c]) + 17'(p_q[ST_SUM-1].qd[c]);
    end

    // rounded dividend for unpremultiply
    for (int c = 0; c < 3; c++) begin
      p_d[ST_DIV_INIT].orem[c] = 18'(p_q[ST_DIV_INIT-1].prem[c])
                               + 18'(p_q[ST_DIV_INIT-1].outa >> 1);
      p_d[ST_DIV_INIT].oq[c]   = '0;
    end

    // unpremultiply divide, one quotient bit per stage
    for (int k = 0; k < OD_BITS; k++) begin
      odv = 18'(p_q[ST_OD0+k-1].outa) << (OD_BITS - 1 - k);
      for (int c = 0; c < 3; c++) begin
        if (p_q[ST_OD0+k-1].orem[c] >= odv) begin
          p_d[ST_OD0+k].orem[c] = p_q[ST_OD0+k-1].orem[c] - odv;
          p_d[ST_OD0+k].oq[c][OD_BITS-1-k] = 1'b1;
        end
      end
    end

    // clamp or pass the destination through
    if (p_q[ST_OUT-1].sa == '0) begin
      p_d[ST_OUT].res   = p_q[ST_OUT-1].dst;
      p_d[ST_OUT].touch = 1'b0;
    end else begin
      for (int c = 0; c < 3; c++) begin
        p_d[ST_OUT].res[c] = p_q[ST_OUT-1].oq[c][8] ? 8'd255 : p_q[ST_OUT-1].oq[c][7:0];
      end
      p_d[ST_OUT].res[3] = p_q[ST_OUT-1].outa[8] ? 8'd255 : p_q[ST_OUT-1].outa[7:0];
      p_d[ST_OUT].touch  = 1'b1;
    end
  end

  // output register
  assign pix_out.valid   = vld_q[ST_OUT];
  assign pix_out.out_r   = p_q[ST_OUT].res[0];
  assign pix_out.out_g   = p_q[ST_OUT].res[1];
  assign pix_out.out_b   = p_q[ST_OUT].res[2];
  assign pix_out.out_a   = p_q[ST_OUT].res[3];
  assign pix_out.touched = p_q[ST_OUT].touch;

endmodule

FILE: rtl/ssab_checker.sv
// port level checks of the soft shape alpha blender
`include "assert_macros.svh"

module ssab_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_r,
  input logic [7:0] out_g,
  input logic [7:0] out_b,
  input logic [7:0] out_a,
  input logic       touched
);

  // a waiting result stays offered
  `SSAB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  // a waiting result keeps its value
  `SSAB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid && !out_ready, $stable({out_r, out_g, out_b, out_a, touched}))
  // input is taken exactly when the pipeline can advance
  `SSAB_ASSERT(a_ready, clk_i, rst_ni, in_ready == (!out_valid || out_ready))
  // a blended pixel never ends up transparent
  `SSAB_ASSERT(a_touch_alpha, clk_i, rst_ni, !(out_valid && touched) || (out_a != 8'd0))

endmodule

bind soft_shape_alpha_blend ssab_checker u_ssab_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_r     (pix_out.out_r),
  .out_g     (pix_out.out_g),
  .out_b     (pix_out.out_b),
  .out_a     (pix_out.out_a),
  .touched   (pix_out.touched)
);
